// ----- sv/fdr_pkg.sv -----
package fdr_pkg;

	// Fixed-point constants.
	localparam logic [15:0] ETA_ONE  = 16'd4096;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [15:0] REFL_ONE = 16'h8000;
	localparam logic [15:0] COS_MAX  = 16'h7FFF;

	// Step counts of the iterative units, one step per pipeline stage.
	localparam int DIV_STEPS  = 30;
	localparam int SQRT_STEPS = 16;
	localparam int RAT_STEPS  = 30;

	// Per-word context that travels the whole pipeline.
	typedef struct packed {
		logic [15:0] c;
		logic [15:0] e;
		logic [15:0] ci;
		logic        pos;
		logic        one;
		logic        zero;
	} ctx_t;

	// Snell division stage: (sin2 << 24) / eta^2.
	typedef struct packed {
		ctx_t        x;
		logic [31:0] e2;
		logic [30:0] ct2n;
		logic        tirn;
		logic        tirp;
		logic [5:0]  lo;
		logic [33:0] r;
		logic [29:0] q;
	} dv_t;

	// Square root stage.
	typedef struct packed {
		ctx_t        x;
		logic        tir;
		logic [30:0] rem;
		logic [15:0] root;
	} sq_t;

	// Stage of the two amplitude ratio dividers.
	typedef struct packed {
		ctx_t        x;
		logic        tir;
		logic [15:0] ct;
		logic [32:0] ds;
		logic [32:0] dp;
		logic [33:0] rs;
		logic [33:0] rp;
		logic [30:0] qs;
		logic [30:0] qp;
	} rt_t;

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	// Returns the quotient bit over the new remainder.
	function automatic logic [34:0] div_step(input logic [33:0] r, input logic [32:0] d,
			input logic b);
		logic [34:0] sh;
		logic [34:0] df;
		begin
			sh = {r, b};
			df = sh - {2'b00, d};
			if (sh >= {2'b00, d}) begin
				div_step = {1'b1, df[33:0]};
			end else begin
				div_step = {1'b0, sh[33:0]};
			end
		end
	endfunction

endpackage

// ----- sv/fdr_if.sv -----
// Incident word channel.
interface fdr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] cos_incident;
	logic [15:0] eta;
	modport source(output valid, output cos_incident, output eta, input ready);
	modport sink(input valid, input cos_incident, input eta, output ready);
endinterface

// Result word channel.
interface fdr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] reflectance;
	logic [15:0] cos_transmitted;
	logic        total_reflection;
	modport source(output valid, output reflectance, output cos_transmitted,
		output total_reflection, input ready);
	modport sink(input valid, input reflectance, input cos_transmitted,
		input total_reflection, output ready);
endinterface

// ----- sv/fresnel_dielectric_reflectance.sv -----
// Channel   Direction  Word
// sample    in         cos_incident (signed Q1.15), eta (unsigned Q4.12)
// result    out        reflectance (Q1.15), cos_transmitted (Q1.15), total_reflection
//
// One word is accepted every cycle unless the result side stalls; the pipeline depth
// is set by the bit-per-stage Snell divider (30), square root (16) and ratio dividers (31).
// Reset clears only the valid bits; the data registers are not reset.
// A stall on the result side freezes the whole pipeline, so sample.ready
// drops only while the output register holds a word that is not taken.
module fresnel_dielectric_reflectance
	import fdr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	fdr_in_if.sink    sample,
	fdr_out_if.source result
);

	logic en;

	// Front stages.
	logic        v_s1, v_s2, v_s3, v_s4;
	ctx_t        x_s1, x_s2, x_s3;
	logic [30:0] sin2_s2, sin2_s3;
	logic [31:0] e2_s2, e2_s3;
	logic [46:0] pl_s3, ph_s3;
	logic        tirp_s3;

	// Iterative unit chains.
	dv_t  dv_s  [0:DIV_STEPS];
	logic dv_v  [0:DIV_STEPS];
	sq_t  sq_s  [0:SQRT_STEPS];
	logic sq_v  [0:SQRT_STEPS];
	rt_t  rt_s  [0:RAT_STEPS];
	logic rt_v  [0:RAT_STEPS];

	// Back stages.
	logic        v_s6, v_s7, v_s9, v_s10;
	ctx_t        x_s6, x_s7, x_s9;
	logic        tir_s6, tir_s7, tir_s9;
	logic [15:0] ct_s6, ct_s7, ct_s9;
	logic [27:0] a_s6, q_s6;
	logic [31:0] b_s6, p_s6;
	logic [31:0] ds_s7, dp_s7;
	logic [32:0] sums_s7, sump_s7;
	logic [61:0] rs2_s9, rp2_s9;
	logic [15:0] refl_s10, cost_s10;
	logic        tir_s10;

	// Combinational helpers.
	ctx_t        x_in;
	logic [31:0] csq;
	logic [62:0] prod;
	logic [29:0] q1;
	logic [30:0] ct2;
	logic [33:0] dss;
	logic [33:0] dps;
	logic [62:0] rsum;
	logic [16:0] rr;

	// The pipeline moves whenever the output register is free or being taken.
	assign en           = !result.valid || result.ready;
	assign sample.ready = en;

	// Input decode.
	always_comb begin
		x_in.c    = sample.cos_incident;
		x_in.e    = sample.eta;
		x_in.ci   = sample.cos_incident[15] ? 16'(-sample.cos_incident) : sample.cos_incident;
		x_in.pos  = !sample.cos_incident[15] && (sample.cos_incident != 16'd0);
		x_in.one  = (sample.eta == ETA_ONE);
		x_in.zero = (sample.eta == 16'd0);
	end

	// Front arithmetic: squares, split product and the direct Snell path.
	assign csq  = x_s1.ci * x_s1.ci;
	assign prod = {ph_s3, 16'd0} + {16'd0, pl_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_in;
			x_s2    <= x_s1;
			sin2_s2 <= ONE_Q30 - csq[30:0];
			e2_s2   <= x_s1.e * x_s1.e;
			x_s3    <= x_s2;
			sin2_s3 <= sin2_s2;
			e2_s3   <= e2_s2;
			pl_s3   <= 47'(sin2_s2) * 47'(e2_s2[15:0]);
			ph_s3   <= 47'(sin2_s2) * 47'(e2_s2[31:16]);
			tirp_s3 <= {7'd0, sin2_s2} >= {e2_s2, 6'd0};
		end
	end

	// Stage 4 seeds the Snell divider and finishes the path for non-positive cosines.
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].x    <= x_s3;
			dv_s[0].e2   <= e2_s3;
			dv_s[0].ct2n <= ONE_Q30 - {1'b0, prod[53:24]};
			dv_s[0].tirn <= |prod[62:54];
			dv_s[0].tirp <= tirp_s3;
			dv_s[0].lo   <= sin2_s3[5:0];
			dv_s[0].r    <= 34'(sin2_s3[30:6]);
			dv_s[0].q    <= '0;
		end
	end
	assign dv_v[0] = v_s4;

	// Snell divider, one quotient bit per stage.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic        bin;
		logic [34:0] st;
		dv_t         nx;
		if (k < 6) begin : g_lo
			assign bin = dv_s[k].lo[5 - k];
		end else begin : g_zero
			assign bin = 1'b0;
		end
		assign st = div_step(dv_s[k].r, {1'b0, dv_s[k].e2}, bin);

		// Next stage contents: context passes through, remainder and quotient advance.
		always_comb begin
			nx   = dv_s[k];
			nx.r = st[33:0];
			nx.q = {dv_s[k].q[DIV_STEPS - 2:0], st[34]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k + 1] <= 1'b0;
			end else if (en) begin
				dv_v[k + 1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k + 1] <= nx;
			end
		end
	end

	// Select the squared transmitted cosine and the total reflection test.
	assign q1  = dv_s[DIV_STEPS].q;
	assign ct2 = dv_s[DIV_STEPS].x.pos ? (ONE_Q30 - {1'b0, q1}) : dv_s[DIV_STEPS].ct2n;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].x    <= dv_s[DIV_STEPS].x;
			sq_s[0].tir  <= dv_s[DIV_STEPS].x.zero ||
				(dv_s[DIV_STEPS].x.pos ? dv_s[DIV_STEPS].tirp : dv_s[DIV_STEPS].tirn);
			sq_s[0].rem  <= ct2;
			sq_s[0].root <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= dv_v[DIV_STEPS];
		end
	end

	// Square root, one result bit per stage from the top.
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam int B = SQRT_STEPS - 1 - k;
		logic [31:0] trial;
		logic        fits;
		sq_t         nx;
		assign trial = (32'(sq_s[k].root) << (B + 1)) | (32'd1 << (2 * B));
		assign fits  = {1'b0, sq_s[k].rem} >= trial;

		// Take the trial bit when it fits under the remainder.
		always_comb begin
			nx = sq_s[k];
			if (fits) begin
				nx.rem  = sq_s[k].rem - trial[30:0];
				nx.root = sq_s[k].root | (16'd1 << B);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k + 1] <= 1'b0;
			end else if (en) begin
				sq_v[k + 1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k + 1] <= nx;
			end
		end
	end

	// Amplitude ratio operands, then their differences and sums.
	assign dss = {2'b00, ds_s7} - {1'b0, sums_s7};
	assign dps = {2'b00, dp_s7} - {1'b0, sump_s7};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			rt_v[0] <= 1'b0;
		end else if (en) begin
			v_s6    <= sq_v[SQRT_STEPS];
			v_s7    <= v_s6;
			rt_v[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s6    <= sq_s[SQRT_STEPS].x;
			tir_s6  <= sq_s[SQRT_STEPS].tir;
			ct_s6   <= sq_s[SQRT_STEPS].root;
			a_s6    <= {sq_s[SQRT_STEPS].x.ci, 12'd0};
			b_s6    <= sq_s[SQRT_STEPS].x.e * sq_s[SQRT_STEPS].root;
			p_s6    <= sq_s[SQRT_STEPS].x.e * sq_s[SQRT_STEPS].x.ci;
			q_s6    <= {sq_s[SQRT_STEPS].root, 12'd0};
			x_s7    <= x_s6;
			tir_s7  <= tir_s6;
			ct_s7   <= ct_s6;
			ds_s7   <= ({4'd0, a_s6} >= b_s6) ? ({4'd0, a_s6} - b_s6) : (b_s6 - {4'd0, a_s6});
			sums_s7 <= {5'd0, a_s6} + {1'b0, b_s6};
			dp_s7   <= (p_s6 >= {4'd0, q_s6}) ? (p_s6 - {4'd0, q_s6}) : ({4'd0, q_s6} - p_s6);
			sump_s7 <= {1'b0, p_s6} + {5'd0, q_s6};
		end
	end

	// First ratio quotient bit: the difference is at most the sum.
	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0].x   <= x_s7;
			rt_s[0].tir <= tir_s7;
			rt_s[0].ct  <= ct_s7;
			rt_s[0].ds  <= sums_s7;
			rt_s[0].dp  <= sump_s7;
			rt_s[0].rs  <= dss[33] ? {2'b00, ds_s7} : dss;
			rt_s[0].rp  <= dps[33] ? {2'b00, dp_s7} : dps;
			rt_s[0].qs  <= {30'd0, !dss[33]};
			rt_s[0].qp  <= {30'd0, !dps[33]};
		end
	end

	// Ratio dividers, both in step, one quotient bit per stage.
	for (genvar k = 0; k < RAT_STEPS; k++) begin : g_rat
		logic [34:0] sts;
		logic [34:0] stp;
		rt_t         nx;
		assign sts = div_step(rt_s[k].rs, rt_s[k].ds, 1'b0);
		assign stp = div_step(rt_s[k].rp, rt_s[k].dp, 1'b0);

		// Next stage contents: both remainders and quotients advance together.
		always_comb begin
			nx    = rt_s[k];
			nx.rs = sts[33:0];
			nx.rp = stp[33:0];
			nx.qs = {rt_s[k].qs[RAT_STEPS - 1:0], sts[34]};
			nx.qp = {rt_s[k].qp[RAT_STEPS - 1:0], stp[34]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v[k + 1] <= 1'b0;
			end else if (en) begin
				rt_v[k + 1] <= rt_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k + 1] <= nx;
			end
		end
	end

	// Squares, then the rounded mean and the output selection.
	assign rsum = {1'b0, rs2_s9} + {1'b0, rp2_s9} + (63'd1 << 45);
	assign rr   = rsum[62:46];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s9  <= rt_v[RAT_STEPS];
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s9   <= rt_s[RAT_STEPS].x;
			tir_s9 <= rt_s[RAT_STEPS].tir;
			ct_s9  <= rt_s[RAT_STEPS].ct;
			rs2_s9 <= rt_s[RAT_STEPS].qs * rt_s[RAT_STEPS].qs;
			rp2_s9 <= rt_s[RAT_STEPS].qp * rt_s[RAT_STEPS].qp;
			if (x_s9.one) begin
				refl_s10 <= '0;
				cost_s10 <= (x_s9.c == REFL_ONE) ? COS_MAX : 16'(-x_s9.c);
				tir_s10  <= 1'b0;
			end else if (tir_s9) begin
				refl_s10 <= REFL_ONE;
				cost_s10 <= '0;
				tir_s10  <= 1'b1;
			end else begin
				refl_s10 <= (rr > 17'(REFL_ONE)) ? REFL_ONE : rr[15:0];
				if (x_s9.pos) begin
					cost_s10 <= 16'(-ct_s9);
				end else begin
					cost_s10 <= (ct_s9 == REFL_ONE) ? COS_MAX : ct_s9;
				end
				tir_s10 <= 1'b0;
			end
		end
	end

	assign result.valid            = v_s10;
	assign result.reflectance      = refl_s10;
	assign result.cos_transmitted  = cost_s10;
	assign result.total_reflection = tir_s10;

endmodule
